@@ src/rgb_to_hsv_converter_defines.svh @@
// Assertion macros shared by the converter's RTL files.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define RHC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_converter: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_converter: next-cycle check failed");

`else

`define RHC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define RHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ src/rhc_pkg.sv @@
package rhc_pkg;

  localparam int CH_W              = 8;
  localparam int HUE_W             = 15;
  localparam int SAT_NUM_W         = 16;
  localparam int HUE_FRAC_BITS_DEF = 6;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_out;
    logic [CH_W-1:0]  sat_out;
    logic [CH_W-1:0]  val_out;
  } hsv_t;

  // Which channel holds the maximum; selects the hue sector offset.
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sect_t;

  // Per-pixel side information that rides along the divider chain.
  typedef struct packed {
    logic            grey;
    logic            black;
    logic            neg;
    sect_t           sect;
    logic [CH_W-1:0] val;
  } side_t;

endpackage

@@ src/rgb_to_hsv_converter.sv @@
// A pixel passes the front-stage register, NSTEPS division cells and the output register,
// where NSTEPS = max(8, bits of 60 << HUE_FRAC_BITS).
// Throughput: one pixel per clock cycle, set by a chain of NSTEPS division cells
// that each resolve one quotient bit of saturation and hue for a different pixel.
// Reset (rst_n low, synchronous) empties the pipeline; busy is high during reset
// and in the cycle after it, then stays low. The receiver cannot stall.
`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter
  import rhc_pkg::*;
#(
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  pixel_t in_data,
  output logic   out_valid,
  output hsv_t   out_data
);

  // Hue scale: one 60 degree sector and the full circle in hue units.
  localparam int SECTOR    = 60 << HUE_FRAC_BITS;
  localparam int HUE_FULL  = 360 << HUE_FRAC_BITS;
  // The hue numerator is SECTOR times a channel difference.
  localparam int HUE_NUM_W = $clog2(SECTOR * 255 + 1);
  // The hue fraction never exceeds one sector; saturation never exceeds 255.
  localparam int HUE_QW    = $clog2(SECTOR + 1);
  localparam int NSTEPS    = (HUE_QW > CH_W) ? HUE_QW : CH_W;
  // Width for assembling the hue before it is cut to the port width.
  localparam int HUE_FW    = $clog2(HUE_FULL + 1);
  localparam int HW        = (HUE_FW > HUE_W) ? HUE_FW : HUE_W;

  // A transaction is taken whenever start is high and busy is low. After
  // reset the block never pushes back, since every stage advances each cycle.
  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Front stage: find max and min, pick the hue sector by channel priority
  // (red, then green, then blue) and form the signed channel difference.
  logic [CH_W-1:0] mx, mn, delta, pos, neg, absd;
  sect_t           sect;
  side_t           side_nxt;

  always_comb begin
    mx = in_data.red;
    mn = in_data.red;
    if (in_data.green > mx) mx = in_data.green;
    if (in_data.blue > mx)  mx = in_data.blue;
    if (in_data.green < mn) mn = in_data.green;
    if (in_data.blue < mn)  mn = in_data.blue;
    delta = mx - mn;

    if (in_data.red == mx) begin
      sect = SECT_RED;
      pos  = in_data.green;
      neg  = in_data.blue;
    end else if (in_data.green == mx) begin
      sect = SECT_GREEN;
      pos  = in_data.blue;
      neg  = in_data.red;
    end else begin
      sect = SECT_BLUE;
      pos  = in_data.red;
      neg  = in_data.green;
    end
    absd = (pos >= neg) ? (pos - neg) : (neg - pos);

    side_nxt.grey  = (delta == '0);
    side_nxt.black = (mx == '0);
    side_nxt.neg   = (pos < neg);
    side_nxt.sect  = sect;
    side_nxt.val   = mx;
  end

  logic            p1_vld_r;
  side_t           p1_side_r;
  logic [CH_W-1:0] p1_delta_r, p1_absd_r, p1_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= accept;
    end
    p1_side_r  <= side_nxt;
    p1_delta_r <= delta;
    p1_absd_r  <= absd;
    p1_max_r   <= mx;
  end

  // Numerators for the two divisions; both are products with constants.
  logic [HUE_NUM_W-1:0] hue_num;
  logic [SAT_NUM_W-1:0] sat_num;

  assign hue_num = HUE_NUM_W'(SECTOR) * HUE_NUM_W'(p1_absd_r);
  assign sat_num = (SAT_NUM_W'(p1_delta_r) << CH_W) - SAT_NUM_W'(p1_delta_r);

  // Division chain: cell k resolves quotient bit NSTEPS-1-k of both lanes.
  // The hue lane divides by delta, the saturation lane by max.
  logic                 c_vld  [0:NSTEPS];
  side_t                c_side [0:NSTEPS];
  logic [HUE_NUM_W-1:0] c_hrem [0:NSTEPS];
  logic [CH_W-1:0]      c_hden [0:NSTEPS];
  logic [NSTEPS-1:0]    c_hq   [0:NSTEPS];
  logic [SAT_NUM_W-1:0] c_srem [0:NSTEPS];
  logic [CH_W-1:0]      c_sden [0:NSTEPS];
  logic [NSTEPS-1:0]    c_sq   [0:NSTEPS];

  assign c_vld[0]  = p1_vld_r;
  assign c_side[0] = p1_side_r;
  assign c_hrem[0] = hue_num;
  assign c_hden[0] = p1_delta_r;
  assign c_hq[0]   = '0;
  assign c_srem[0] = sat_num;
  assign c_sden[0] = p1_max_r;
  assign c_sq[0]   = '0;

  for (genvar k = 0; k < NSTEPS; k++) begin : g_cell
    rhc_div_cell #(
      .HUE_NUM_W (HUE_NUM_W),
      .QW        (NSTEPS),
      .BIT       (NSTEPS - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .vld_i     (c_vld[k]),
      .side_i    (c_side[k]),
      .hue_rem_i (c_hrem[k]),
      .hue_den_i (c_hden[k]),
      .hue_q_i   (c_hq[k]),
      .sat_rem_i (c_srem[k]),
      .sat_den_i (c_sden[k]),
      .sat_q_i   (c_sq[k]),
      .vld_o     (c_vld[k+1]),
      .side_o    (c_side[k+1]),
      .hue_rem_o (c_hrem[k+1]),
      .hue_den_o (c_hden[k+1]),
      .hue_q_o   (c_hq[k+1]),
      .sat_rem_o (c_srem[k+1]),
      .sat_den_o (c_sden[k+1]),
      .sat_q_o   (c_sq[k+1])
    );
  end

  // Back stage: add the sector base to the fraction, or subtract it for a
  // negative difference. A negative result can only happen in the red sector
  // and wraps around by a full circle. Grey pixels get hue zero and black
  // pixels get saturation zero, covering the divisions by zero.
  side_t             fin_side;
  logic [HW-1:0]     frac, base, hue_full;
  logic [CH_W-1:0]   sat_fin;
  hsv_t              out_nxt;

  always_comb begin
    fin_side = c_side[NSTEPS];
    frac     = HW'(c_hq[NSTEPS][HUE_QW-1:0]);
    case (fin_side.sect)
      SECT_RED:   base = '0;
      SECT_GREEN: base = HW'(2 * SECTOR);
      SECT_BLUE:  base = HW'(4 * SECTOR);
      default:    base = '0;
    endcase

    if (fin_side.grey) begin
      hue_full = '0;
    end else if (!fin_side.neg) begin
      hue_full = base + frac;
    end else if (base >= frac) begin
      hue_full = base - frac;
    end else begin
      hue_full = HW'(HUE_FULL) - frac;
    end

    sat_fin = fin_side.black ? '0 : c_sq[NSTEPS][CH_W-1:0];

    out_nxt.hue_out = hue_full[HUE_W-1:0];
    out_nxt.sat_out = sat_fin;
    out_nxt.val_out = fin_side.val;
  end

  logic out_valid_r;
  hsv_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c_vld[NSTEPS];
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A black pixel has neither saturation nor hue; zero saturation means a
  // grey pixel, so hue must be zero too; an accepted pixel enters the chain.
  `RHC_ASSERT_IMPLY(a_black_zero, clk, rst_n, out_valid && (out_data.val_out == '0), (out_data.sat_out == '0) && (out_data.hue_out == '0))
  `RHC_ASSERT_IMPLY(a_grey_hue, clk, rst_n, out_valid && (out_data.sat_out == '0), out_data.hue_out == '0)
  `RHC_ASSERT_NEXT(a_accept_enters, clk, rst_n, start && !busy, p1_vld_r)

endmodule

@@ src/rhc_div_cell.sv @@
`include "rgb_to_hsv_converter_defines.svh"

module rhc_div_cell
  import rhc_pkg::*;
#(
  parameter int HUE_NUM_W = 22,
  parameter int QW        = 12,
  parameter int BIT       = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  side_t                side_i,
  input  logic [HUE_NUM_W-1:0] hue_rem_i,
  input  logic [CH_W-1:0]      hue_den_i,
  input  logic [QW-1:0]        hue_q_i,
  input  logic [SAT_NUM_W-1:0] sat_rem_i,
  input  logic [CH_W-1:0]      sat_den_i,
  input  logic [QW-1:0]        sat_q_i,
  output logic                 vld_o,
  output side_t                side_o,
  output logic [HUE_NUM_W-1:0] hue_rem_o,
  output logic [CH_W-1:0]      hue_den_o,
  output logic [QW-1:0]        hue_q_o,
  output logic [SAT_NUM_W-1:0] sat_rem_o,
  output logic [CH_W-1:0]      sat_den_o,
  output logic [QW-1:0]        sat_q_o
);

  // Compare widths large enough for the divisor shifted by this cell's bit.
  localparam int SH_W = CH_W + BIT;
  localparam int HXW  = (SH_W > HUE_NUM_W) ? SH_W : HUE_NUM_W;
  localparam int SXW  = (SH_W > SAT_NUM_W) ? SH_W : SAT_NUM_W;

  logic                 vld_r;
  side_t                side_r;
  logic [HUE_NUM_W-1:0] hue_rem_r, hue_rem_nxt;
  logic [CH_W-1:0]      hue_den_r;
  logic [QW-1:0]        hue_q_r, hue_q_nxt;
  logic [SAT_NUM_W-1:0] sat_rem_r, sat_rem_nxt;
  logic [CH_W-1:0]      sat_den_r;
  logic [QW-1:0]        sat_q_r, sat_q_nxt;

  logic [HXW-1:0] hue_rem_x, hue_sh;
  logic [SXW-1:0] sat_rem_x, sat_sh;
  logic           hue_bit, sat_bit;

  // One restoring division step per lane: try to subtract divisor << BIT.
  always_comb begin
    hue_rem_x   = HXW'(hue_rem_i);
    hue_sh      = HXW'(hue_den_i) << BIT;
    hue_bit     = (hue_rem_x >= hue_sh);
    hue_rem_nxt = hue_bit ? HUE_NUM_W'(hue_rem_x - hue_sh) : hue_rem_i;
    hue_q_nxt   = {hue_q_i[QW-2:0], hue_bit};

    sat_rem_x   = SXW'(sat_rem_i);
    sat_sh      = SXW'(sat_den_i) << BIT;
    sat_bit     = (sat_rem_x >= sat_sh);
    sat_rem_nxt = sat_bit ? SAT_NUM_W'(sat_rem_x - sat_sh) : sat_rem_i;
    sat_q_nxt   = {sat_q_i[QW-2:0], sat_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    side_r    <= side_i;
    hue_rem_r <= hue_rem_nxt;
    hue_den_r <= hue_den_i;
    hue_q_r   <= hue_q_nxt;
    sat_rem_r <= sat_rem_nxt;
    sat_den_r <= sat_den_i;
    sat_q_r   <= sat_q_nxt;
  end

  assign vld_o     = vld_r;
  assign side_o    = side_r;
  assign hue_rem_o = hue_rem_r;
  assign hue_den_o = hue_den_r;
  assign hue_q_o   = hue_q_r;
  assign sat_rem_o = sat_rem_r;
  assign sat_den_o = sat_den_r;
  assign sat_q_o   = sat_q_r;

  // The remainder left behind must be below the divisor at this bit weight.
  logic [HXW-1:0] hue_rem_chk, hue_sh_chk;
  logic [SXW-1:0] sat_rem_chk, sat_sh_chk;
  assign hue_rem_chk = HXW'(hue_rem_r);
  assign hue_sh_chk  = HXW'(hue_den_r) << BIT;
  assign sat_rem_chk = SXW'(sat_rem_r);
  assign sat_sh_chk  = SXW'(sat_den_r) << BIT;

  `RHC_ASSERT_IMPLY(a_hue_rem_bound, clk, rst_n, vld_r && (hue_den_r != '0), hue_rem_chk < hue_sh_chk)
  `RHC_ASSERT_IMPLY(a_sat_rem_bound, clk, rst_n, vld_r && (sat_den_r != '0), sat_rem_chk < sat_sh_chk)
  `RHC_ASSERT_IMPLY(a_grey_den, clk, rst_n, vld_r && (hue_den_r == '0), side_r.grey)

endmodule

@@ tb/tb.sv @@
module tb;
  import rhc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The converter is built at its default hue resolution. The sector width and
  // the full circle follow from it, as does the pipeline depth that the header
  // of the RTL gives.
  localparam int HUE_FRAC = HUE_FRAC_BITS_DEF;
  localparam int unsigned SECTOR = 60 << HUE_FRAC;
  localparam int unsigned FULL_TURN = 360 << HUE_FRAC;
  localparam int SECTOR_BITS = $clog2(SECTOR + 1);
  localparam int DIV_STEPS = (SECTOR_BITS > 8) ? SECTOR_BITS : 8;
  localparam int PIPE_LATENCY = DIV_STEPS + 2;

  // The run is aborted after this many cycles in which no transaction moves on
  // either side. The longest correct quiet stretch is a long sender gap or a full
  // trip through the pipeline, so this is ample.
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PIXELS = 1880;

  // One pending pixel for the driver. The idle count is the number of cycles
  // that the driver waits before it offers the pixel. When drain is set, the
  // driver also holds the pixel back until every earlier result has come out.
  typedef struct {
    pixel_t      pix;
    int unsigned idle;
    bit          drain;
  } pixel_job_t;

  logic   clk;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  pixel_t in_data = '0;
  logic   out_valid;
  hsv_t   out_data;

  pixel_job_t  pixel_q[$];
  hsv_t        expected_hsv[int];
  int          n_sent = 0;
  int          n_done = 0;
  int          gap_cnt = 0;
  int          quiet_cycles = 0;
  int          mismatch_cnt = 0;
  int          n_directed = 0;
  int          n_drains = 0;

  rgb_to_hsv_converter #(
    .HUE_FRAC_BITS(HUE_FRAC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hue, saturation and value of one pixel, computed with exact integer
  // arithmetic. The hue is the sector offset of the largest channel plus the
  // truncated fraction of a sector; a negative hue can only arise in the red
  // sector and wraps around by a full turn.
  function automatic hsv_t predict_hsv(pixel_t px);
    int unsigned r, g, b, top, low, span, sat, hue, base, up, dn, frac;
    hsv_t res;
    r = 32'(px.red);
    g = 32'(px.green);
    b = 32'(px.blue);
    top = r;
    low = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < low) low = g;
    if (b < low) low = b;
    span = top - low;
    sat = 0;
    hue = 0;
    if (top != 0) sat = (255 * span) / top;
    if (span != 0) begin
      // Red wins a tie for the maximum, then green.
      if (r == top) begin
        base = 0;
        up = g;
        dn = b;
      end else if (g == top) begin
        base = 2 * SECTOR;
        up = b;
        dn = r;
      end else begin
        base = 4 * SECTOR;
        up = r;
        dn = g;
      end
      if (up >= dn) begin
        hue = base + (SECTOR * (up - dn)) / span;
      end else begin
        frac = (SECTOR * (dn - up)) / span;
        hue = (base >= frac) ? base - frac : FULL_TURN - (frac - base);
      end
    end
    res.hue_out = hue[HUE_W-1:0];
    res.sat_out = sat[CH_W-1:0];
    res.val_out = top[CH_W-1:0];
    return res;
  endfunction

  task automatic queue_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b, input int unsigned idle,
                             input bit drain);
    pixel_job_t job;
    job.pix.red = r;
    job.pix.green = g;
    job.pix.blue = b;
    job.idle = idle;
    job.drain = drain;
    pixel_q.push_back(job);
  endtask

  // Driver. A transaction completes at an edge where start is high and busy
  // is low; the expected result is recorded under its sequence number at that
  // edge. The next pixel is then offered once its idle count has elapsed and,
  // for a draining pixel, once the pipeline has emptied. Each output gets
  // exactly one nonblocking assignment per edge, so start stays high across
  // back-to-back transactions.
  always @(posedge clk) begin : drive
    logic   take;
    logic   nxt_start;
    pixel_t nxt_pix;
    int     nxt_gap;
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      gap_cnt <= 0;
    end else begin
      take = start && !busy;
      nxt_start = start && !take;
      nxt_pix = in_data;
      nxt_gap = gap_cnt;
      if (take) begin
        expected_hsv[n_sent] = predict_hsv(in_data);
        n_sent <= n_sent + 1;
      end
      if (!nxt_start && pixel_q.size() != 0) begin
        if (gap_cnt < pixel_q[0].idle) begin
          nxt_gap = gap_cnt + 1;
        end else if (!pixel_q[0].drain || (!take && n_done == n_sent)) begin
          nxt_pix = pixel_q.pop_front().pix;
          nxt_start = 1'b1;
          nxt_gap = 0;
        end
      end
      start <= nxt_start;
      in_data <= nxt_pix;
      gap_cnt <= nxt_gap;
    end
  end

  // Monitor. A result is on the ports for one cycle only, so every strobe is
  // checked at the edge that ends that cycle against the oldest outstanding
  // expectation. The sequence counters are only updated with nonblocking
  // assignments, so both blocks see the same values at any edge.
  always @(posedge clk) begin : check
    hsv_t want;
    if (rst_n && out_valid) begin
      if (n_done == n_sent) begin
        mismatch_cnt++;
        $display("%0t: expected no result, actual hue %0d sat %0d val %0d",
                 $time, out_data.hue_out, out_data.sat_out, out_data.val_out);
      end else begin
        want = expected_hsv[n_done];
        expected_hsv.delete(n_done);
        n_done <= n_done + 1;
        if (out_data.hue_out !== want.hue_out) begin
          mismatch_cnt++;
          $display("%0t: pixel %0d hue: expected %0d, actual %0d",
                   $time, n_done, want.hue_out, out_data.hue_out);
        end
        if (out_data.sat_out !== want.sat_out) begin
          mismatch_cnt++;
          $display("%0t: pixel %0d saturation: expected %0d, actual %0d",
                   $time, n_done, want.sat_out, out_data.sat_out);
        end
        if (out_data.val_out !== want.val_out) begin
          mismatch_cnt++;
          $display("%0t: pixel %0d value: expected %0d, actual %0d",
                   $time, n_done, want.val_out, out_data.val_out);
        end
      end
    end
  end

  // Watchdog. Any transaction on either side restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, giving up", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int          mode;
    int          kind;
    int unsigned idle;
    logic [CH_W-1:0] a, c, e;

    // Directed pixels: black, white, grey, the primaries and secondaries, every
    // kind of tie for the maximum, hue wrap-around in the red sector, and the
    // smallest nonzero channels.
    queue_pixel(8'd0,   8'd0,   8'd0,   0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 0, 1'b0);
    queue_pixel(8'd128, 8'd128, 8'd128, 0, 1'b0);
    queue_pixel(8'd1,   8'd1,   8'd1,   0, 1'b0);
    queue_pixel(8'd255, 8'd0,   8'd0,   0, 1'b0);
    queue_pixel(8'd0,   8'd255, 8'd0,   1, 1'b0);
    queue_pixel(8'd0,   8'd0,   8'd255, 0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd0,   0, 1'b0);
    queue_pixel(8'd0,   8'd255, 8'd255, 3, 1'b0);
    queue_pixel(8'd255, 8'd0,   8'd255, 0, 1'b0);
    queue_pixel(8'd255, 8'd0,   8'd1,   0, 1'b0);
    queue_pixel(8'd255, 8'd0,   8'd254, 0, 1'b0);
    queue_pixel(8'd1,   8'd0,   8'd0,   0, 1'b0);
    queue_pixel(8'd0,   8'd1,   8'd0,   0, 1'b0);
    queue_pixel(8'd0,   8'd0,   8'd1,   0, 1'b0);
    queue_pixel(8'd255, 8'd254, 8'd0,   0, 1'b0);
    queue_pixel(8'd0,   8'd255, 8'd254, 0, 1'b0);
    queue_pixel(8'd254, 8'd0,   8'd255, 0, 1'b0);
    queue_pixel(8'd200, 8'd200, 8'd50,  0, 1'b1);
    queue_pixel(8'd50,  8'd200, 8'd200, 0, 1'b0);
    queue_pixel(8'd200, 8'd50,  8'd200, 0, 1'b0);
    queue_pixel(8'd170, 8'd85,  8'd0,   0, 1'b0);
    queue_pixel(8'd255, 8'd1,   8'd254, 0, 1'b0);
    queue_pixel(8'd2,   8'd1,   8'd0,   0, 1'b0);
    n_directed = pixel_q.size();
    n_drains = 1;

    // Random pixels in stretches of 64. Each stretch has its own idle pattern:
    // back to back, mostly short gaps, or short gaps with the odd long one.
    // Most pixels are uniform; the rest stress greys, ties, tiny channels and
    // the channel extremes.
    mode = 0;
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: begin
          idle = 0;
        end
        1, 2: begin
          idle = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
        end
        default: begin
          if ($urandom_range(0, 15) == 0) idle = $urandom_range(20, 60);
          else idle = $urandom_range(0, 2);
        end
      endcase
      a = CH_W'($urandom_range(0, 255));
      c = CH_W'($urandom_range(0, 255));
      e = CH_W'($urandom_range(0, 255));
      kind = $urandom_range(0, 9);
      case (kind)
        6: begin
          queue_pixel(a, a, a, idle, 1'b0);
        end
        7: begin
          // Two channels share the maximum, or at least share a value.
          case ($urandom_range(0, 2))
            0: queue_pixel(a, a, e, idle, 1'b0);
            1: queue_pixel(e, a, a, idle, 1'b0);
            default: queue_pixel(a, e, a, idle, 1'b0);
          endcase
        end
        8: begin
          queue_pixel(CH_W'($urandom_range(0, 3)), CH_W'($urandom_range(0, 3)),
                      CH_W'($urandom_range(0, 3)), idle, 1'b0);
        end
        9: begin
          queue_pixel($urandom_range(0, 1) ? 8'd255 : a, $urandom_range(0, 1) ? 8'd0 : c,
                      $urandom_range(0, 1) ? 8'd255 : e, idle, 1'b0);
        end
        default: begin
          queue_pixel(a, c, e, idle, (i % 250 == 125));
        end
      endcase
      if (kind <= 5 && i % 250 == 125) n_drains++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait at the falling edge, away from the driver and monitor updates, until
    // every pixel has gone in and every result has come out. Then give a late
    // or extra result the time of a full pipeline pass to show up.
    do begin
      @(negedge clk);
    end while (pixel_q.size() != 0 || start || n_done != n_sent);
    repeat (PIPE_LATENCY + 4) @(negedge clk);

    $display("Converted %0d pixels (%0d directed, the rest random) with %0d pipeline drains,",
             n_done, n_directed, n_drains);
    $display("covering black, grey, ties for the maximum, hue wrap-around and random gaps.");
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches found", mismatch_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
